[hdl/crcfr_pkg.sv]
// ----------------------------------------------------------------------------
// CRC-8 command frame receiver package
// Shared types, constants and the byte-wide CRC-8 update function.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    localparam int BYTE_W = 8;
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_TOP = 8'h80;

    typedef enum logic [2:0] {
        PH_SYNC = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CHK  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ARG    = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] arg_count;
        logic [BYTE_W-1:0] arg_index;
        logic [BYTE_W-1:0] arg_value;
        logic              link_active;
    } result_t;

    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c & CRC_TOP) != '0) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hdl/crc8_command_frame_receiver.sv]
// ----------------------------------------------------------------------------
// CRC-8 command frame receiver
// Deframes sync, command, length, arguments and check byte with a CRC-8 check.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle on the slave stream and never
// stalls it except when two results are already waiting behind a stalled
// master stream. Argument bytes, and the verdict on a frame given on its check
// byte, pass through the output register before they come out; sync,
// command and length bytes produce nothing. The CRC-8 (polynomial 0x07, zero
// start) covers the sync, command, length and argument bytes. Arguments are
// not held back, so a consumer drops the arguments of a frame whose verdict
// is a rejection. The sync byte value is written on the cfg port, which is
// always ready, and takes effect at the next hunt for a frame.
module crc8_command_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,     // sync_value
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,      // command, arg_count, arg_index, arg_value,
                                      // link_active, zero fill
    output logic [1:0]  m_tuser       // kind
);
    import crcfr_pkg::*;

    logic    rx_accept;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign cfg_ready = 1'b1;
    assign rx_accept = s_tvalid && s_tready;

    crcfr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid),
        .cfg_data  (cfg_data),
        .rx_accept (rx_accept),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    crcfr_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {7'd0, out_res.link_active, out_res.arg_value, out_res.arg_index,
                      out_res.arg_count, out_res.command};

endmodule

[hdl/crcfr_core.sv]
// ----------------------------------------------------------------------------
// CRC-8 command frame receiver core
// Frame state machine, running CRC and result formation for one byte a cycle while bytes are accepted.
// ----------------------------------------------------------------------------
module crcfr_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_write,
    input  logic [7:0]              cfg_data,
    input  logic                    rx_accept,
    input  logic [7:0]              rx_byte,
    output logic                    res_valid,
    output crcfr_pkg::result_t      res
);
    import crcfr_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   sync_value_reg, sync_value_next;
    logic [BYTE_W-1:0]   command_reg, command_next;
    logic [BYTE_W-1:0]   length_reg, length_next;
    logic [BYTE_W-1:0]   position_reg, position_next;
    logic [BYTE_W-1:0]   crc_reg, crc_next;
    logic                active_reg, active_next;
    logic [BYTE_W-1:0]   crc_step;
    logic [BYTE_W-1:0]   position_inc;

    assign crc_step     = crc8_update(crc_reg, rx_byte);
    assign position_inc = position_reg + 8'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SYNC;
            sync_value_reg <= SYNC_RESET;
            command_reg    <= '0;
            length_reg     <= '0;
            position_reg   <= '0;
            crc_reg        <= '0;
            active_reg     <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            sync_value_reg <= sync_value_next;
            command_reg    <= command_next;
            length_reg     <= length_next;
            position_reg   <= position_next;
            crc_reg        <= crc_next;
            active_reg     <= active_next;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        sync_value_next = cfg_write ? cfg_data : sync_value_reg;
        command_next    = command_reg;
        length_next     = length_reg;
        position_next   = position_reg;
        crc_next        = crc_reg;
        active_next     = active_reg;
        res_valid       = 1'b0;
        res.kind        = KIND_ARG;
        res.command     = command_reg;
        res.arg_count   = length_reg;
        res.arg_index   = '0;
        res.arg_value   = '0;
        res.link_active = active_reg;
        if (rx_accept) begin
            case (phase_reg)
                PH_CMD: begin
                    command_next = rx_byte;
                    crc_next     = crc_step;
                    phase_next   = PH_LEN;
                end
                PH_LEN: begin
                    length_next   = rx_byte;
                    position_next = '0;
                    crc_next      = crc_step;
                    phase_next    = (rx_byte == '0) ? PH_CHK : PH_DATA;
                end
                PH_DATA: begin
                    crc_next      = crc_step;
                    position_next = position_inc;
                    if (position_inc >= length_reg) begin
                        phase_next = PH_CHK;
                    end
                    res_valid     = 1'b1;
                    res.kind      = KIND_ARG;
                    res.arg_index = position_reg;
                    res.arg_value = rx_byte;
                end
                PH_CHK: begin
                    phase_next = PH_SYNC;
                    res_valid  = 1'b1;
                    if (crc_reg == rx_byte) begin
                        active_next     = 1'b1;
                        res.kind        = KIND_ACCEPT;
                        res.link_active = 1'b1;
                    end else begin
                        res.kind = KIND_REJECT;
                    end
                end
                default: begin
                    phase_next = PH_SYNC;
                    if (rx_byte == sync_value_reg) begin
                        crc_next   = crc8_update('0, rx_byte);
                        phase_next = PH_CMD;
                    end
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cmd_to_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (rx_accept && phase_reg == PH_CMD) |=> (phase_reg == PH_LEN))
        else $error("command byte did not advance to the length phase");

    a_active_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(active_reg))
        else $error("link active flag cleared outside reset");

    a_accept_sets_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.kind == KIND_ACCEPT) |=> active_reg)
        else $error("accepted frame did not set the link active flag");

    a_result_needs_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (rx_accept && (phase_reg == PH_DATA || phase_reg == PH_CHK)))
        else $error("result produced without an argument or check byte");
`endif

endmodule

[hdl/crcfr_out_buf.sv]
// ----------------------------------------------------------------------------
// CRC-8 command frame receiver output buffer
// Result register with a skid stage so the input side waits only while the skid stage is full.
// ----------------------------------------------------------------------------
module crcfr_out_buf (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    input  crcfr_pkg::result_t      in_data,
    output logic                    in_ready,
    output logic                    out_valid,
    output crcfr_pkg::result_t      out_data,
    input  logic                    out_ready
);
    import crcfr_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg, main_data_next;
    result_t skid_data_reg, skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_valid;
                main_data_next  = in_data;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage holds a result while the main stage is empty");

    a_stall_keeps_main: assert property (@(posedge aclk) disable iff (!aresetn)
        (main_valid_reg && !out_ready) |=> main_valid_reg)
        else $error("stalled result was dropped");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid stage did not move into the main stage");
`endif

endmodule
